// ===== rtl/core/qdv_pkg.sv =====
// ----------------------------------------------------------------------------
// qdv_pkg
// Shared types, codes and defaults for the dual quadrature decoder with
// window speed and position tracking.
// ----------------------------------------------------------------------------
package qdv_pkg;

  localparam int WINDOW_BITS_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;

  localparam int CMD_W      = 2;
  localparam int SPEED_W    = 16;
  localparam int POS_OUT_W  = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CMD_W-1:0] CMD_PIN_EVENT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR_POS = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_LEFT_INVERT  = 1'b0;
  localparam logic REG_RIGHT_INVERT = 1'b1;

  localparam logic LEFT_INVERT_RST  = 1'b1;
  localparam logic RIGHT_INVERT_RST = 1'b0;

  typedef struct packed {
    logic a_edge;
    logic b_edge;
    logic a_level;
    logic b_level;
  } wheel_pins_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    wheel_pins_t      left;
    wheel_pins_t      right;
  } in_item_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0]   speed;
    logic signed [POS_OUT_W-1:0] position;
    logic signed [SPEED_W-1:0]   window_count;
  } wheel_res_t;

  typedef struct packed {
    logic left_invert;
    logic right_invert;
  } cfg_regs_t;

endpackage

// ===== rtl/core/qdv_in_if.sv =====
// ----------------------------------------------------------------------------
// qdv_in_if
// Request channel carrying one command with both wheels' pin edges and levels.
// ----------------------------------------------------------------------------
interface qdv_in_if;
  logic                       valid;
  logic                       ready;
  logic [qdv_pkg::CMD_W-1:0]  command;
  logic                       left_a_edge;
  logic                       left_b_edge;
  logic                       left_a_level;
  logic                       left_b_level;
  logic                       right_a_edge;
  logic                       right_b_edge;
  logic                       right_a_level;
  logic                       right_b_level;

  modport source (
    output valid, command,
    output left_a_edge, left_b_edge, left_a_level, left_b_level,
    output right_a_edge, right_b_edge, right_a_level, right_b_level,
    input  ready
  );

  modport sink (
    input  valid, command,
    input  left_a_edge, left_b_edge, left_a_level, left_b_level,
    input  right_a_edge, right_b_edge, right_a_level, right_b_level,
    output ready
  );
endinterface

// ===== rtl/core/qdv_out_if.sv =====
// ----------------------------------------------------------------------------
// qdv_out_if
// Result channel carrying speeds, positions and raw window counts.
// ----------------------------------------------------------------------------
interface qdv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [qdv_pkg::SPEED_W-1:0]    left_speed;
  logic signed [qdv_pkg::SPEED_W-1:0]    right_speed;
  logic signed [qdv_pkg::POS_OUT_W-1:0]  left_position;
  logic signed [qdv_pkg::POS_OUT_W-1:0]  right_position;
  logic signed [qdv_pkg::SPEED_W-1:0]    left_window_count;
  logic signed [qdv_pkg::SPEED_W-1:0]    right_window_count;

  modport source (
    output valid, left_speed, right_speed, left_position, right_position,
    output left_window_count, right_window_count,
    input  ready
  );

  modport sink (
    input  valid, left_speed, right_speed, left_position, right_position,
    input  left_window_count, right_window_count,
    output ready
  );
endinterface

// ===== rtl/core/qdv_cfg.sv =====
// ----------------------------------------------------------------------------
// qdv_cfg
// APB register file holding the per-wheel invert bits.
// ----------------------------------------------------------------------------
module qdv_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qdv_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [qdv_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [qdv_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output qdv_pkg::cfg_regs_t               regs
);
  import qdv_pkg::*;

  cfg_regs_t regs_r, regs_nxt;
  logic      wr_en;
  logic      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_ADDR_W-1];

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (reg_idx)
        REG_LEFT_INVERT:  regs_nxt.left_invert  = pwdata[0];
        REG_RIGHT_INVERT: regs_nxt.right_invert = pwdata[0];
        default:          regs_nxt = regs_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEFT_INVERT:  prdata = {{(CFG_DATA_W-1){1'b0}}, regs_r.left_invert};
      REG_RIGHT_INVERT: prdata = {{(CFG_DATA_W-1){1'b0}}, regs_r.right_invert};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.left_invert  <= LEFT_INVERT_RST;
      regs_r.right_invert <= RIGHT_INVERT_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ===== rtl/core/qdv_wheel.sv =====
// ----------------------------------------------------------------------------
// qdv_wheel
// One wheel: x4 quadrature count, saturating window counter, latched
// velocity and wrapping position integral, plus result formatting.
// ----------------------------------------------------------------------------
module qdv_wheel #(
  parameter int WINDOW_BITS   = qdv_pkg::WINDOW_BITS_DEF,
  parameter int POSITION_BITS = qdv_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        update,
  input  logic [qdv_pkg::CMD_W-1:0]   command,
  input  qdv_pkg::wheel_pins_t        pins,
  input  logic                        invert,
  output qdv_pkg::wheel_res_t         res_nxt
);
  import qdv_pkg::*;

  localparam logic signed [WINDOW_BITS:0] LIMIT = {2'b00, {(WINDOW_BITS-1){1'b1}}};
  localparam int EXT_W     = WINDOW_BITS + SPEED_W;
  localparam int POS_EXT_W = POSITION_BITS + POS_OUT_W;

  logic signed [WINDOW_BITS-1:0]   window_r, window_nxt;
  logic signed [WINDOW_BITS-1:0]   velocity_r, velocity_nxt;
  logic        [POSITION_BITS-1:0] integral_r, integral_nxt;

  logic                            differ;
  logic signed [1:0]               delta;
  logic signed [WINDOW_BITS:0]     win_sum;
  logic signed [WINDOW_BITS-1:0]   win_sat;
  logic signed [EXT_W-1:0]         vel_ext;
  logic signed [EXT_W-1:0]         win_ext;
  logic        [POSITION_BITS-1:0] pos_v;
  logic signed [POS_EXT_W-1:0]     pos_ext;

  // net count; both edges together cancel
  always_comb begin
    differ = pins.a_level ^ pins.b_level;
    case ({pins.a_edge, pins.b_edge})
      2'b10:   delta = differ ? 2'sb01 : 2'sb11;
      2'b01:   delta = differ ? 2'sb11 : 2'sb01;
      default: delta = 2'sb00;
    endcase
  end

  always_comb begin
    win_sum = {window_r[WINDOW_BITS-1], window_r} + (WINDOW_BITS+1)'(delta);
    if (win_sum > LIMIT) begin
      win_sat = LIMIT[WINDOW_BITS-1:0];
    end else if (win_sum < -LIMIT) begin
      win_sat = -LIMIT[WINDOW_BITS-1:0];
    end else begin
      win_sat = win_sum[WINDOW_BITS-1:0];
    end
  end

  always_comb begin
    window_nxt   = window_r;
    velocity_nxt = velocity_r;
    integral_nxt = integral_r;
    case (command)
      CMD_PIN_EVENT: begin
        window_nxt   = win_sat;
        integral_nxt = integral_r + POSITION_BITS'(delta);
      end
      CMD_TICK: begin
        velocity_nxt = window_r;
        window_nxt   = '0;
      end
      CMD_CLEAR_POS: begin
        integral_nxt = '0;
      end
      default: begin
        window_nxt = window_r;
      end
    endcase
  end

  // results come from the state after this request
  always_comb begin
    vel_ext = EXT_W'(velocity_nxt);
    if (invert) begin
      vel_ext = -vel_ext;
    end
    win_ext = EXT_W'(window_nxt);
    pos_v   = invert ? (POSITION_BITS'(0) - integral_nxt) : integral_nxt;
    pos_ext = POS_EXT_W'($signed(pos_v));
    res_nxt.speed        = vel_ext[SPEED_W-1:0];
    res_nxt.window_count = win_ext[SPEED_W-1:0];
    res_nxt.position     = pos_ext[POS_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= '0;
      velocity_r <= '0;
      integral_r <= '0;
    end else if (update) begin
      window_r   <= window_nxt;
      velocity_r <= velocity_nxt;
      integral_r <= integral_nxt;
    end
  end

endmodule

// ===== rtl/core/dual_quadrature_decoder_velocity_unit.sv =====
// ----------------------------------------------------------------------------
// dual_quadrature_decoder_velocity_unit
// Two-wheel x4 quadrature decoder with per-window speed and position.
//
//   channel | direction | handshake         | content
//   --------+-----------+-------------------+------------------------------
//   in_chan | sink      | valid/ready       | command, edges, levels
//   out_chan| source    | valid/ready       | speeds, positions, window counts
//   cfg_*   | slave     | APB, pready tied  | left/right invert bits
//
// One request per clock while the result side is not stalled. A request is
// taken into the input register, then moves into the result register, where
// the wheel state is updated. When the result register is held by a stalled
// sink, the input register holds too and in_chan.ready drops once it is full.
// Reset clears all wheel counters, positions, speeds and both valid flags.
// ----------------------------------------------------------------------------
module dual_quadrature_decoder_velocity_unit #(
  parameter int WINDOW_BITS   = qdv_pkg::WINDOW_BITS_DEF,
  parameter int POSITION_BITS = qdv_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  qdv_in_if.sink                           in_chan,
  qdv_out_if.source                        out_chan,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [qdv_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [qdv_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [qdv_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import qdv_pkg::*;

  cfg_regs_t  cfg_regs;
  in_item_t   in_item;
  in_item_t   s1_item_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_adv;
  logic       in_take;
  logic       out_valid_r, out_valid_nxt;
  wheel_res_t left_res_nxt, right_res_nxt;
  wheel_res_t left_res_r, right_res_r;

  qdv_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (cfg_regs)
  );

  assign in_item.command       = in_chan.command;
  assign in_item.left.a_edge   = in_chan.left_a_edge;
  assign in_item.left.b_edge   = in_chan.left_b_edge;
  assign in_item.left.a_level  = in_chan.left_a_level;
  assign in_item.left.b_level  = in_chan.left_b_level;
  assign in_item.right.a_edge  = in_chan.right_a_edge;
  assign in_item.right.b_edge  = in_chan.right_b_edge;
  assign in_item.right.a_level = in_chan.right_a_level;
  assign in_item.right.b_level = in_chan.right_b_level;

  // advance the input register whenever the result register can take it
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  qdv_wheel #(
    .WINDOW_BITS   (WINDOW_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_wheel_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .update  (s1_adv),
    .command (s1_item_r.command),
    .pins    (s1_item_r.left),
    .invert  (cfg_regs.left_invert),
    .res_nxt (left_res_nxt)
  );

  qdv_wheel #(
    .WINDOW_BITS   (WINDOW_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_wheel_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .update  (s1_adv),
    .command (s1_item_r.command),
    .pins    (s1_item_r.right),
    .invert  (cfg_regs.right_invert),
    .res_nxt (right_res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      left_res_r  <= left_res_nxt;
      right_res_r <= right_res_nxt;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.left_speed         = left_res_r.speed;
  assign out_chan.right_speed        = right_res_r.speed;
  assign out_chan.left_position      = left_res_r.position;
  assign out_chan.right_position     = right_res_r.position;
  assign out_chan.left_window_count  = left_res_r.window_count;
  assign out_chan.right_window_count = right_res_r.window_count;

endmodule

// ===== rtl/core/qdv_checker.sv =====
// ----------------------------------------------------------------------------
// qdv_checker
// Port-level checks on the decoder: result hold, request flow and register
// readback.
// ----------------------------------------------------------------------------
module qdv_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [qdv_pkg::SPEED_W-1:0]      left_speed,
  input logic [qdv_pkg::POS_OUT_W-1:0]    left_position,
  input logic [qdv_pkg::SPEED_W-1:0]      right_window_count,
  input logic                             cfg_psel,
  input logic                             cfg_penable,
  input logic                             cfg_pwrite,
  input logic [qdv_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input logic [qdv_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  input logic [qdv_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  input logic                             cfg_pready
);
  import qdv_pkg::*;

  logic cfg_wr;
  logic cfg_rd;

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_rd = cfg_psel && !cfg_pwrite;

  // result is cleared by reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(left_speed) && $stable(left_position) && $stable(right_window_count))
    else $error("result changed while stalled");

  // a free sink must never back-pressure the request side
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("request blocked with sink ready");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr ##1 (cfg_rd && cfg_paddr[CFG_ADDR_W-1] == $past(cfg_paddr[CFG_ADDR_W-1]))
      |-> cfg_prdata[0] == $past(cfg_pwdata[0]))
    else $error("register readback mismatch");

endmodule

bind dual_quadrature_decoder_velocity_unit qdv_checker u_qdv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .left_speed         (out_chan.left_speed),
  .left_position      (out_chan.left_position),
  .right_window_count (out_chan.right_window_count),
  .cfg_psel           (cfg_psel),
  .cfg_penable        (cfg_penable),
  .cfg_pwrite         (cfg_pwrite),
  .cfg_paddr          (cfg_paddr),
  .cfg_pwdata         (cfg_pwdata),
  .cfg_prdata         (cfg_prdata),
  .cfg_pready         (cfg_pready)
);

// ===== bench/qdv_odometry_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdv_odometry_checker
// Tracks both wheels' window counters, latched speeds and positions from the
// accepted requests and the invert bits seen on the register port. Every
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module qdv_odometry_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  qdv_in_if                              in_mon,
  qdv_out_if                             out_mon,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic                           cfg_pready,
  input  logic [qdv_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [qdv_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output int                             mismatch_count,
  output int                             results_owed
);
  import qdv_pkg::*;

  localparam int WIN_W   = WINDOW_BITS_DEF;
  localparam int POS_W   = POSITION_BITS_DEF;
  localparam int WIN_MAX = 2 ** (WIN_W - 1) - 1;

  typedef struct packed {
    wheel_res_t left;
    wheel_res_t right;
  } odometry_t;

  logic signed [WIN_W-1:0] left_window;
  logic signed [WIN_W-1:0] right_window;
  logic signed [WIN_W-1:0] left_speed;
  logic signed [WIN_W-1:0] right_speed;
  logic [POS_W-1:0]        left_pos;
  logic [POS_W-1:0]        right_pos;
  logic                    left_invert;
  logic                    right_invert;
  odometry_t               owed_q[$];

  // x4 decoding: the sense of a count follows whether the levels now differ
  function automatic int wheel_count(wheel_pins_t pins);
    int delta;
    delta = 0;
    if (pins.a_edge) delta += (pins.a_level != pins.b_level) ? 1 : -1;
    if (pins.b_edge) delta += (pins.a_level != pins.b_level) ? -1 : 1;
    return delta;
  endfunction

  function automatic logic signed [WIN_W-1:0] window_add(logic signed [WIN_W-1:0] win,
                                                         int delta);
    int sum;
    sum = int'(win) + delta;
    if (sum > WIN_MAX) sum = WIN_MAX;
    else if (sum < -WIN_MAX) sum = -WIN_MAX;
    return WIN_W'(sum);
  endfunction

  function automatic wheel_res_t wheel_result(logic signed [WIN_W-1:0] speed,
                                              logic signed [WIN_W-1:0] win,
                                              logic [POS_W-1:0] pos, logic invert);
    wheel_res_t res;
    res.speed        = invert ? -speed : speed;
    res.position     = invert ? -pos : pos;
    res.window_count = win;
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic take_request();
    in_item_t  req;
    odometry_t res;
    int        left_delta;
    int        right_delta;
    req.command = in_mon.command;
    req.left    = {in_mon.left_a_edge, in_mon.left_b_edge,
                   in_mon.left_a_level, in_mon.left_b_level};
    req.right   = {in_mon.right_a_edge, in_mon.right_b_edge,
                   in_mon.right_a_level, in_mon.right_b_level};
    case (req.command)
      CMD_PIN_EVENT: begin
        left_delta   = wheel_count(req.left);
        right_delta  = wheel_count(req.right);
        left_window  = window_add(left_window, left_delta);
        right_window = window_add(right_window, right_delta);
        left_pos     = left_pos + POS_W'(left_delta);
        right_pos    = right_pos + POS_W'(right_delta);
      end
      CMD_TICK: begin
        left_speed   = left_window;
        right_speed  = right_window;
        left_window  = '0;
        right_window = '0;
      end
      CMD_CLEAR_POS: begin
        left_pos  = '0;
        right_pos = '0;
      end
      default: ;  // unused code: hold all state
    endcase
    res.left  = wheel_result(left_speed, left_window, left_pos, left_invert);
    res.right = wheel_result(right_speed, right_window, right_pos, right_invert);
    owed_q.push_back(res);
  endtask

  task automatic check_result();
    odometry_t want;
    if (owed_q.size() == 0) begin
      $error("result with no request outstanding");
      mismatch_count++;
      return;
    end
    want = owed_q.pop_front();
    check_field("left_speed", $signed(want.left.speed), out_mon.left_speed);
    check_field("right_speed", $signed(want.right.speed), out_mon.right_speed);
    check_field("left_position", $signed(want.left.position), out_mon.left_position);
    check_field("right_position", $signed(want.right.position), out_mon.right_position);
    check_field("left_window_count", $signed(want.left.window_count),
                out_mon.left_window_count);
    check_field("right_window_count", $signed(want.right.window_count),
                out_mon.right_window_count);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      left_window    = '0;
      right_window   = '0;
      left_speed     = '0;
      right_speed    = '0;
      left_pos       = '0;
      right_pos      = '0;
      left_invert    = LEFT_INVERT_RST;
      right_invert   = RIGHT_INVERT_RST;
      mismatch_count = 0;
      owed_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[2])
          REG_LEFT_INVERT:  left_invert  = cfg_pwdata[0];
          REG_RIGHT_INVERT: right_invert = cfg_pwdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) take_request();
    end
    results_owed = owed_q.size();
  end

endmodule

// ===== bench/tb_dual_quadrature_decoder_velocity_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_quadrature_decoder_velocity_unit
// Drives the two-wheel decoder with directed pin events and random phases
// of encoder motion mixed with ticks, position clears and noise, under
// several invert settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_dual_quadrature_decoder_velocity_unit;
  import qdv_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 255;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int         mismatch_count;
  int         results_owed;
  int         sender_idle_pct;
  int         sink_stall_pct;
  int         quiet_cycles;
  logic [1:0] left_phase;
  logic [1:0] right_phase;
  int         left_dir;
  int         right_dir;

  qdv_in_if  in_if ();
  qdv_out_if out_if ();

  dual_quadrature_decoder_velocity_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  qdv_odometry_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_pready     (cfg_pready),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_psel)
    begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // wheel nibble order, MSB first: a_edge, b_edge, a_level, b_level
  function automatic in_item_t request(logic [CMD_W-1:0] cmd, logic [3:0] left,
                                       logic [3:0] right);
    in_item_t req;
    req.command = cmd;
    req.left    = left;
    req.right   = right;
    return req;
  endfunction

  // Gray sequence of (A, B): 00, 10, 11, 01 counts up
  task automatic step_wheel(inout logic [1:0] phase, inout int dir,
                            output wheel_pins_t pins);
    logic [1:0] next;
    if ($urandom_range(9) == 0) dir = -dir;
    next = ($urandom_range(4) == 0) ? phase : phase + 2'(dir);
    pins.a_level = next[1] ^ next[0];
    pins.b_level = next[1];
    pins.a_edge  = pins.a_level ^ phase[1] ^ phase[0];
    pins.b_edge  = pins.b_level ^ phase[1];
    phase = next;
  endtask

  task automatic random_request(output in_item_t req);
    int pick;
    pick = $urandom_range(99);
    req  = $bits(in_item_t)'($urandom);
    if (pick < 72) begin
      req.command = CMD_PIN_EVENT;
      step_wheel(left_phase, left_dir, req.left);
      step_wheel(right_phase, right_dir, req.right);
    end else if (pick < 82) begin
      req.command = CMD_TICK;
    end else if (pick < 86) begin
      req.command = CMD_CLEAR_POS;
    end else if (pick < 89) begin
      req.command = CMD_UNUSED;
    end else if (pick < 97) begin
      req.command = CMD_PIN_EVENT;  // arbitrary edges and levels
    end
  endtask

  task automatic push_request(input in_item_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.command       = req.command;
    in_if.left_a_edge   = req.left.a_edge;
    in_if.left_b_edge   = req.left.b_edge;
    in_if.left_a_level  = req.left.a_level;
    in_if.left_b_level  = req.left.b_level;
    in_if.right_a_edge  = req.right.a_edge;
    in_if.right_b_edge  = req.right.b_edge;
    in_if.right_a_level = req.right.a_level;
    in_if.right_b_level = req.right.b_level;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic reg_index, input logic value);
    cfg_paddr   = {reg_index, 2'b00};
    cfg_pwdata  = CFG_DATA_W'(value);
    cfg_pwrite  = 1'b1;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  initial begin
    logic     left_setting[PHASES]  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    logic     right_setting[PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    int       idle_setting[PHASES]  = '{0, 48, 0, 38, 0, 38};
    int       stall_setting[PHASES] = '{0, 0, 48, 38, 0, 38};
    in_item_t req;

    rst_n           = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    in_if.valid     = 1'b0;
    in_if.command   = CMD_PIN_EVENT;
    {in_if.left_a_edge, in_if.left_b_edge, in_if.left_a_level, in_if.left_b_level} = '0;
    {in_if.right_a_edge, in_if.right_b_edge, in_if.right_a_level, in_if.right_b_level} = '0;
    out_if.ready    = 1'b1;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    quiet_cycles    = 0;
    left_phase      = '0;
    right_phase     = '0;
    left_dir        = 1;
    right_dir       = -1;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed requests under the reset invert settings
    push_request(request(CMD_PIN_EVENT, 4'b0000, 4'b1111));  // both edges, net zero
    push_request(request(CMD_PIN_EVENT, 4'b1010, 4'b1011));  // A edge: differ up, equal down
    push_request(request(CMD_PIN_EVENT, 4'b0110, 4'b0100));  // B edge: differ down, equal up
    push_request(request(CMD_PIN_EVENT, 4'b1101, 4'b1100));
    push_request(request(CMD_PIN_EVENT, 4'b1111, 4'b1110));
    push_request(request(CMD_PIN_EVENT, 4'b1001, 4'b0111));
    push_request(request(CMD_PIN_EVENT, 4'b1001, 4'b0111));
    push_request(request(CMD_TICK, 4'b1111, 4'b1111));       // pins ignored
    push_request(request(CMD_PIN_EVENT, 4'b1000, 4'b1000));
    push_request(request(CMD_CLEAR_POS, 4'b1010, 4'b0110));
    push_request(request(CMD_UNUSED, 4'b1010, 4'b1010));
    push_request(request(CMD_PIN_EVENT, 4'b1000, 4'b0100));
    push_request(request(CMD_TICK, 4'b0000, 4'b0000));
    push_request(request(CMD_UNUSED, 4'b1111, 4'b1111));
    push_request(request(CMD_TICK, 4'b0101, 4'b1010));
    push_request(request(CMD_CLEAR_POS, 4'b0000, 4'b0000));
    push_request(request(CMD_TICK, 4'b0000, 4'b0000));
    push_request(request(CMD_TICK, 4'b0000, 4'b0000));
    push_request(request(CMD_PIN_EVENT, 4'b1011, 4'b1010));
    push_request(request(CMD_CLEAR_POS, 4'b0000, 4'b0000));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_register(REG_LEFT_INVERT, left_setting[p]);
      write_register(REG_RIGHT_INVERT, right_setting[p]);
      sender_idle_pct = idle_setting[p];
      sink_stall_pct  = stall_setting[p];
      repeat (PHASE_ITEMS) begin
        random_request(req);
        push_request(req);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
